### rtl/sfd_pkg.sv
// Shared types and constants for the sync header frame deframer.
// Used by the event interface and all deframer modules; depends on nothing.
package sfd_pkg;

    localparam int HEADER_BYTES = 11;
    localparam int COUNT_BITS   = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 10;
    localparam int HDR_IDX_BITS = 4;
    localparam int LEFT_BITS    = 20;
    localparam int AREA_BITS    = 19;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_TYPE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_HEIGHT  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_FRAME_TYPE = 8'h01;
    localparam logic [9:0] RST_MAX_WIDTH  = 10'd640;
    localparam logic [8:0] RST_MAX_HEIGHT = 9'd480;

    // Event codes on the result channel.
    localparam logic [2:0] EVT_HDR_OK    = 3'd0;
    localparam logic [2:0] EVT_PAYLOAD   = 3'd1;
    localparam logic [2:0] EVT_FRAME_OK  = 3'd2;
    localparam logic [2:0] EVT_BAD_HDR   = 3'd3;
    localparam logic [2:0] EVT_BAD_CHECK = 3'd4;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] frame_type;
        logic [9:0] max_width;
        logic [8:0] max_height;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic [2:0]            event_kind;
        logic [7:0]            payload_byte;
        logic [15:0]           frame_id;
        logic [15:0]           frame_width;
        logic [15:0]           frame_height;
        logic [COUNT_BITS-1:0] good_count;
        logic [COUNT_BITS-1:0] bad_count;
    } t_evt;

endpackage

### rtl/sfd_rx_if.sv
// Byte input channel of the deframer: valid/ready handshake and one byte.
// Depends on nothing.
interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/sfd_evt_if.sv
// Event output channel of the deframer: valid/ready handshake and event fields.
// Depends on sfd_pkg for the counter width.
interface sfd_evt_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     event_kind;
    logic [7:0]                     payload_byte;
    logic [15:0]                    frame_id;
    logic [15:0]                    frame_width;
    logic [15:0]                    frame_height;
    logic [sfd_pkg::COUNT_BITS-1:0] good_count;
    logic [sfd_pkg::COUNT_BITS-1:0] bad_count;

    modport source (output valid, output event_kind, output payload_byte,
                    output frame_id, output frame_width, output frame_height,
                    output good_count, output bad_count, input ready);
    modport sink   (input valid, input event_kind, input payload_byte,
                    input frame_id, input frame_width, input frame_height,
                    input good_count, input bad_count, output ready);
endinterface

### rtl/sfd_cfg_regs.sv
// Configuration register bank of the deframer, written through a plain write port.
// Depends on sfd_pkg.
module sfd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [sfd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output sfd_pkg::t_cfg                     o_cfg
);

    sfd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= 8'd0;
            r_cfg.sync_second <= 8'd0;
            r_cfg.frame_type  <= sfd_pkg::RST_FRAME_TYPE;
            r_cfg.max_width   <= sfd_pkg::RST_MAX_WIDTH;
            r_cfg.max_height  <= sfd_pkg::RST_MAX_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfd_pkg::CFG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data[7:0];
                sfd_pkg::CFG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data[7:0];
                sfd_pkg::CFG_FRAME_TYPE:  r_cfg.frame_type  <= i_cfg_data[7:0];
                sfd_pkg::CFG_MAX_WIDTH:   r_cfg.max_width   <= i_cfg_data[9:0];
                sfd_pkg::CFG_MAX_HEIGHT:  r_cfg.max_height  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/sfd_parser.sv
// Frame parser: sync hunt, header capture and check, payload count and checksum.
// Processes one byte per step; depends on sfd_pkg.
module sfd_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfd_pkg::t_cfg i_cfg,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    output sfd_pkg::t_evt o_res
);

    localparam logic [2:0] PH_SYNC0   = 3'd0;
    localparam logic [2:0] PH_SYNC1   = 3'd1;
    localparam logic [2:0] PH_HEADER  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK0  = 3'd4;
    localparam logic [2:0] PH_CHECK1  = 3'd5;

    localparam logic [sfd_pkg::HDR_IDX_BITS-1:0] LAST_IDX =
        sfd_pkg::HDR_IDX_BITS'(sfd_pkg::HEADER_BYTES - 1);

    logic [2:0]                          r_phase, n_phase;
    logic [sfd_pkg::HDR_IDX_BITS-1:0]    r_idx, n_idx;
    logic [15:0]                         r_sum, n_sum;
    logic [sfd_pkg::LEFT_BITS-1:0]       r_left, n_left;
    logic [7:0]                          r_chk, n_chk;
    logic [sfd_pkg::COUNT_BITS-1:0]      r_good, n_good;
    logic [sfd_pkg::COUNT_BITS-1:0]      r_bad, n_bad;
    logic [7:0]                          r_hdr [sfd_pkg::HEADER_BYTES];
    logic [sfd_pkg::AREA_BITS-1:0]       r_area;

    logic        hdr_we;
    logic        emit;
    logic [2:0]  kind;
    logic [7:0]  pbyte;
    logic [15:0] hdr_w, hdr_h;
    logic [31:0] hdr_len;
    logic        hdr_ok;
    logic [15:0] be_sum, le_sum, sync_sum;
    logic        check_ok;

    assign hdr_w   = {r_hdr[3], r_hdr[4]};
    assign hdr_h   = {r_hdr[5], r_hdr[6]};
    // The last length byte is the byte being processed right now.
    assign hdr_len = {r_hdr[7], r_hdr[8], r_hdr[9], i_byte};

    // Width and height are complete several bytes before the header ends, so
    // their product settles in r_area ahead of the length comparison.
    assign hdr_ok = (r_hdr[0] == i_cfg.frame_type)
                 && (hdr_w != 16'd0) && (hdr_h != 16'd0)
                 && (hdr_w <= {6'd0, i_cfg.max_width})
                 && (hdr_h <= {7'd0, i_cfg.max_height})
                 && (hdr_len == {12'd0, r_area, 1'b0});

    assign be_sum   = {r_chk, i_byte};
    assign le_sum   = {i_byte, r_chk};
    assign sync_sum = r_sum + {8'd0, i_cfg.sync_first} + {8'd0, i_cfg.sync_second};
    assign check_ok = (r_sum == be_sum) || (sync_sum == be_sum)
                   || (r_sum == le_sum) || (sync_sum == le_sum);

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_sum   = r_sum;
        n_left  = r_left;
        n_chk   = r_chk;
        n_good  = r_good;
        n_bad   = r_bad;
        hdr_we  = 1'b0;
        emit    = 1'b0;
        kind    = sfd_pkg::EVT_HDR_OK;
        pbyte   = 8'd0;
        if (i_step) begin
            case (r_phase)
                PH_SYNC1: begin
                    if (i_byte == i_cfg.sync_second) begin
                        n_phase = PH_HEADER;
                        n_idx   = '0;
                        n_sum   = 16'd0;
                    end else if (i_byte != i_cfg.sync_first) begin
                        n_phase = PH_SYNC0;
                    end
                end
                PH_HEADER: begin
                    hdr_we = 1'b1;
                    n_sum  = r_sum + {8'd0, i_byte};
                    n_idx  = r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_idx = '0;
                        emit  = 1'b1;
                        if (hdr_ok) begin
                            n_left  = hdr_len[sfd_pkg::LEFT_BITS-1:0];
                            n_phase = PH_PAYLOAD;
                            kind    = sfd_pkg::EVT_HDR_OK;
                        end else begin
                            n_bad   = r_bad + 1'b1;
                            n_phase = PH_SYNC0;
                            kind    = sfd_pkg::EVT_BAD_HDR;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_sum = r_sum + {8'd0, i_byte};
                    if (r_left != '0) begin
                        n_left = r_left - 1'b1;
                    end
                    if (n_left == '0) begin
                        n_phase = PH_CHECK0;
                    end
                    emit  = 1'b1;
                    kind  = sfd_pkg::EVT_PAYLOAD;
                    pbyte = i_byte;
                end
                PH_CHECK0: begin
                    n_chk   = i_byte;
                    n_phase = PH_CHECK1;
                end
                PH_CHECK1: begin
                    n_phase = PH_SYNC0;
                    emit    = 1'b1;
                    if (check_ok) begin
                        n_good = r_good + 1'b1;
                        kind   = sfd_pkg::EVT_FRAME_OK;
                    end else begin
                        n_bad = r_bad + 1'b1;
                        kind  = sfd_pkg::EVT_BAD_CHECK;
                    end
                end
                default: begin
                    n_phase = (i_byte == i_cfg.sync_first) ? PH_SYNC1 : PH_SYNC0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC0;
            r_idx   <= '0;
            r_sum   <= 16'd0;
            r_left  <= '0;
            r_chk   <= 8'd0;
            r_good  <= '0;
            r_bad   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
            r_left  <= n_left;
            r_chk   <= n_chk;
            r_good  <= n_good;
            r_bad   <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[r_idx] <= i_byte;
        end
        r_area <= {9'd0, hdr_w[9:0]} * {10'd0, hdr_h[8:0]};
    end

    always_comb begin
        o_res.valid        = emit;
        o_res.event_kind   = kind;
        o_res.payload_byte = pbyte;
        o_res.frame_id     = {r_hdr[1], r_hdr[2]};
        o_res.frame_width  = hdr_w;
        o_res.frame_height = hdr_h;
        o_res.good_count   = n_good;
        o_res.bad_count    = n_bad;
    end

endmodule

### rtl/sync_header_frame_deframer_unit.sv
// Top level of the sync header frame deframer: input register, parser, result register.
// Depends on sfd_pkg, sfd_rx_if, sfd_evt_if, sfd_cfg_regs and sfd_parser.
//
// Usage: received bytes enter on i_rx, one byte per transaction. The block
// hunts for the two programmed sync bytes, collects the 11-byte header,
// checks it and then streams each payload byte out on o_evt, followed by a
// frame good or bad checksum event after the two checksum bytes. The last
// header byte gives a header ok event, or a bad header event if the check fails.
// Sync bytes, header bytes other than the last and the first checksum byte
// cause no output transaction.
// A byte is processed while it sits in the input register, and its event,
// if any, passes through the result register before it appears on o_evt.
// One byte is taken every cycle as long as the output side keeps up; the
// result register lets a new byte be accepted while an event waits.
// When the receiver stalls with an event pending, the parser holds the byte
// in the input register and i_rx.ready drops once that register is full.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while the
// block is idle; writes to unused indexes are ignored.
// Reset (synchronous, active low) restores the register defaults, clears
// both counters and returns the parser to hunting for the first sync byte.
module sync_header_frame_deframer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [sfd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    sfd_rx_if.sink                            i_rx,
    sfd_evt_if.source                         o_evt
);

    sfd_pkg::t_cfg cfg;
    sfd_pkg::t_evt res;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    sfd_pkg::t_evt r_out;
    logic       step;

    // The parser advances whenever a byte is waiting and any pending event
    // leaves the result register in the same cycle.
    assign step       = r_in_valid && (!r_out_valid || o_evt.ready);
    assign i_rx.ready = !r_in_valid || step;

    sfd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res.valid;
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.valid) begin
            r_out <= res;
        end
    end

    assign o_evt.valid        = r_out_valid;
    assign o_evt.event_kind   = r_out.event_kind;
    assign o_evt.payload_byte = r_out.payload_byte;
    assign o_evt.frame_id     = r_out.frame_id;
    assign o_evt.frame_width  = r_out.frame_width;
    assign o_evt.frame_height = r_out.frame_height;
    assign o_evt.good_count   = r_out.good_count;
    assign o_evt.bad_count    = r_out.bad_count;

endmodule

### tb/testbench.sv
// Self-checking testbench for the sync header frame deframer unit.
// Depends on sfd_pkg, sfd_rx_if, sfd_evt_if and the deframer RTL; reads no files.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected transaction on the event channel, field by field.
    typedef struct packed {
        logic [2:0]                     kind;
        logic [7:0]                     payload;
        logic [15:0]                    frame_id;
        logic [15:0]                    frame_width;
        logic [15:0]                    frame_height;
        logic [sfd_pkg::COUNT_BITS-1:0] good_count;
        logic [sfd_pkg::COUNT_BITS-1:0] bad_count;
    } t_deframe_evt;

    // A row of the directed table. When fixed is set the expected event is
    // written into the row instead of coming from the predictor.
    typedef struct packed {
        logic [7:0]   rx;
        bit           fixed;
        t_deframe_evt want;
    } t_dir_row;

    typedef enum logic [2:0] {
        HUNT_FIRST, HUNT_SECOND, IN_HEADER, IN_PAYLOAD, CHECK_HI, CHECK_LO
    } t_parse_phase;

    typedef enum int {ALWAYS_READY, RANDOM_READY, PATTERN_READY, SLOW_READY} t_recv_mode;
    typedef enum int {
        BAD_TYPE, ZERO_WIDTH, ZERO_HEIGHT, TOO_WIDE, TOO_TALL, BAD_LENGTH, NO_FLAW
    } t_header_flaw;
    typedef enum int {PLAIN_SYNC, REPEATED_FIRST, BROKEN_SYNC} t_sync_lead;

    localparam logic [7:0] STALL_PATTERN = 8'b1101_0110;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [sfd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [sfd_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    sfd_rx_if  rx_if ();
    sfd_evt_if evt_if ();

    sync_header_frame_deframer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_if),
        .o_evt      (evt_if)
    );

    // Free-running clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: a private copy of the parser and of the registers.
    t_parse_phase                   m_phase;
    int unsigned                    m_hdr_idx;
    logic [7:0]                     m_hdr [sfd_pkg::HEADER_BYTES];
    logic [19:0]                    m_left;
    logic [15:0]                    m_sum;
    logic [7:0]                     m_check_hi;
    logic [sfd_pkg::COUNT_BITS-1:0] m_good;
    logic [sfd_pkg::COUNT_BITS-1:0] m_bad;
    sfd_pkg::t_cfg                  m_cfg;

    t_deframe_evt pending_events[$];
    t_dir_row     dir_rows[$];
    int           mismatch_count = 0;
    int           bytes_accepted = 0;
    int           burst_left = 0;
    bit           steady_source = 1'b0;

    // Receiver side: ready is driven from its own pattern generator.
    logic         sink_ready = 1'b0;
    t_recv_mode   ready_mode = ALWAYS_READY;
    logic [15:0]  ready_cycle = '0;

    assign evt_if.ready = sink_ready;

    function automatic void reset_model();
        m_phase    = HUNT_FIRST;
        m_hdr_idx  = 0;
        foreach (m_hdr[i]) m_hdr[i] = 8'h00;
        m_left     = '0;
        m_sum      = '0;
        m_check_hi = '0;
        m_good     = '0;
        m_bad      = '0;
        m_cfg      = sfd_pkg::t_cfg'{8'h00, 8'h00, sfd_pkg::RST_FRAME_TYPE,
                                     sfd_pkg::RST_MAX_WIDTH, sfd_pkg::RST_MAX_HEIGHT};
    endfunction

    function automatic logic [15:0] hdr_word(int at);
        return {m_hdr[at], m_hdr[at+1]};
    endfunction

    // Every event carries the id and size of the header seen last, together
    // with both frame counters as they stand after this byte.
    function automatic t_deframe_evt make_evt(logic [2:0] kind, logic [7:0] payload);
        t_deframe_evt e;
        e.kind         = kind;
        e.payload      = payload;
        e.frame_id     = hdr_word(1);
        e.frame_width  = hdr_word(3);
        e.frame_height = hdr_word(5);
        e.good_count   = m_good;
        e.bad_count    = m_bad;
        return e;
    endfunction

    // Advances the predicted parser by one received byte and tells whether
    // an event results, and which.
    function automatic void deframe_step(input logic [7:0] b, output bit has_evt,
                                         output t_deframe_evt e);
        logic [15:0] w, h, be, le, with_sync;
        logic [31:0] len;
        logic [63:0] area2;
        bit          ok;
        has_evt = 1'b0;
        e = '0;
        case (m_phase)
            HUNT_SECOND: begin
                // A repeated first sync byte keeps the hunt for the second one alive.
                if (b == m_cfg.sync_second) begin
                    m_phase   = IN_HEADER;
                    m_hdr_idx = 0;
                    m_sum     = '0;
                end else if (b != m_cfg.sync_first) begin
                    m_phase = HUNT_FIRST;
                end
            end
            IN_HEADER: begin
                m_hdr[m_hdr_idx] = b;
                m_hdr_idx++;
                m_sum = m_sum + 16'(b);
                if (m_hdr_idx == sfd_pkg::HEADER_BYTES) begin
                    w     = hdr_word(3);
                    h     = hdr_word(5);
                    len   = {hdr_word(7), hdr_word(9)};
                    area2 = 64'(w) * 64'(h) * 64'd2;
                    ok = (m_hdr[0] == m_cfg.frame_type) && (w != 0) && (h != 0) &&
                         (w <= m_cfg.max_width) && (h <= m_cfg.max_height) &&
                         (64'(len) == area2);
                    m_hdr_idx = 0;
                    has_evt   = 1'b1;
                    if (!ok) begin
                        m_bad   = m_bad + 1'b1;
                        m_phase = HUNT_FIRST;
                        e = make_evt(sfd_pkg::EVT_BAD_HDR, 8'h00);
                    end else begin
                        m_left  = len[19:0];
                        m_phase = IN_PAYLOAD;
                        e = make_evt(sfd_pkg::EVT_HDR_OK, 8'h00);
                    end
                end
            end
            IN_PAYLOAD: begin
                m_sum = m_sum + 16'(b);
                if (m_left != 0) m_left = m_left - 1'b1;
                if (m_left == 0) m_phase = CHECK_HI;
                has_evt = 1'b1;
                e = make_evt(sfd_pkg::EVT_PAYLOAD, b);
            end
            CHECK_HI: begin
                m_check_hi = b;
                m_phase    = CHECK_LO;
            end
            CHECK_LO: begin
                // The checksum may cover the sync bytes or not, and may be
                // sent in either byte order.
                be        = {m_check_hi, b};
                le        = {b, m_check_hi};
                with_sync = m_sum + 16'(m_cfg.sync_first) + 16'(m_cfg.sync_second);
                m_phase   = HUNT_FIRST;
                has_evt   = 1'b1;
                if (m_sum == be || with_sync == be || m_sum == le || with_sync == le) begin
                    m_good = m_good + 1'b1;
                    e = make_evt(sfd_pkg::EVT_FRAME_OK, 8'h00);
                end else begin
                    m_bad = m_bad + 1'b1;
                    e = make_evt(sfd_pkg::EVT_BAD_CHECK, 8'h00);
                end
            end
            default: begin
                m_phase = (b == m_cfg.sync_first) ? HUNT_SECOND : HUNT_FIRST;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("check failed on %s at %0t: got 0x%0h, expected 0x%0h",
                 what, $realtime, got, want);
        mismatch_count++;
    endtask

    function automatic void add_row(input logic [7:0] rx, input bit fixed = 1'b0,
                                    input t_deframe_evt want = '0);
        dir_rows.push_back(t_dir_row'{rx, fixed, want});
    endfunction

    // Sends one byte as an input transaction. The sender works in bursts; a
    // new burst may start after a gap with valid low. The expectation is
    // queued once the transaction has happened.
    task automatic push_byte(input logic [7:0] b, input bit fixed, input t_deframe_evt want);
        bit           has_evt;
        t_deframe_evt e;
        int           gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = steady_source ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_accepted++;
        deframe_step(b, has_evt, e);
        if (fixed) begin
            pending_events.push_back(want);
        end else if (has_evt) begin
            pending_events.push_back(e);
        end
    endtask

    // Stops sending and waits until every queued event has come out, then waits
    // longer so that a byte without an event has also left the pipeline.
    task automatic wait_drained();
        int guard;
        rx_if.valid <= 1'b0;
        guard = 0;
        while (pending_events.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_events.size() != 0) begin
            report_mismatch("events never delivered", 32'(pending_events.size()), 32'd0);
            pending_events.delete();
        end
        repeat (6) @(posedge i_clk);
    endtask

    // Writes all five registers back to back; only called while idle.
    task automatic set_config(input sfd_pkg::t_cfg c);
        logic [sfd_pkg::CFG_IDX_BITS-1:0]  reg_order [5];
        logic [sfd_pkg::CFG_DATA_BITS-1:0] data;
        reg_order = '{sfd_pkg::CFG_SYNC_FIRST, sfd_pkg::CFG_SYNC_SECOND,
                      sfd_pkg::CFG_FRAME_TYPE, sfd_pkg::CFG_MAX_WIDTH,
                      sfd_pkg::CFG_MAX_HEIGHT};
        foreach (reg_order[k]) begin
            case (reg_order[k])
                sfd_pkg::CFG_SYNC_FIRST:  data = sfd_pkg::CFG_DATA_BITS'(c.sync_first);
                sfd_pkg::CFG_SYNC_SECOND: data = sfd_pkg::CFG_DATA_BITS'(c.sync_second);
                sfd_pkg::CFG_FRAME_TYPE:  data = sfd_pkg::CFG_DATA_BITS'(c.frame_type);
                sfd_pkg::CFG_MAX_WIDTH:   data = sfd_pkg::CFG_DATA_BITS'(c.max_width);
                default:                  data = sfd_pkg::CFG_DATA_BITS'(c.max_height);
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= reg_order[k];
            i_cfg_data <= data;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        m_cfg = c;
    endtask

    // Short runs of junk, biased toward the sync values so that half-formed
    // sync sequences occur often.
    task automatic send_noise();
        int         n;
        int         pick;
        logic [7:0] x;
        n = $urandom_range(1, 6);
        repeat (n) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) x = m_cfg.sync_first;
            else if (pick == 1) x = m_cfg.sync_second;
            else x = 8'($urandom_range(0, 255));
            push_byte(x, 1'b0, '0);
        end
    endtask

    // One frame with random content: mostly well formed, sometimes with a
    // broken header or checksum, and with a few ways of leading into the sync.
    task automatic send_frame();
        logic [7:0]   sf, ss, ftype, x;
        logic [15:0]  fid, w, h, sum, csum;
        logic [31:0]  len;
        logic [87:0]  hdr_bits;
        int           cap_w, cap_h, pick;
        t_header_flaw flaw;
        t_sync_lead   lead;
        sf = m_cfg.sync_first;
        ss = m_cfg.sync_second;
        pick = $urandom_range(0, 5);
        if (sf == ss) lead = PLAIN_SYNC;
        else if (pick == 1) lead = REPEATED_FIRST;
        else if (pick == 2) lead = BROKEN_SYNC;
        else lead = PLAIN_SYNC;
        if (lead == REPEATED_FIRST) begin
            push_byte(sf, 1'b0, '0);
            push_byte(sf, 1'b0, '0);
        end else if (lead == BROKEN_SYNC) begin
            push_byte(sf, 1'b0, '0);
            do x = 8'($urandom_range(0, 255)); while (x == sf || x == ss);
            push_byte(x, 1'b0, '0);
        end
        push_byte(sf, 1'b0, '0);
        push_byte(ss, 1'b0, '0);

        // Most frames are tiny; now and then one is a little larger.
        cap_w = ($urandom_range(0, 9) == 0) ? 24 : 4;
        cap_h = ($urandom_range(0, 9) == 0) ? 24 : 3;
        if (cap_w > m_cfg.max_width) cap_w = m_cfg.max_width;
        if (cap_h > m_cfg.max_height) cap_h = m_cfg.max_height;
        w     = 16'($urandom_range(1, cap_w));
        h     = 16'($urandom_range(1, cap_h));
        ftype = m_cfg.frame_type;
        fid   = 16'($urandom_range(0, 65535));
        pick  = $urandom_range(0, 29);
        flaw  = (pick < 6) ? t_header_flaw'(pick) : NO_FLAW;
        case (flaw)
            BAD_TYPE:    ftype = ftype ^ 8'(1 << $urandom_range(0, 7));
            ZERO_WIDTH:  w = '0;
            ZERO_HEIGHT: h = '0;
            TOO_WIDE:    w = $urandom_range(0, 1) ? 16'hFFFF :
                             16'(m_cfg.max_width) + 16'($urandom_range(1, 3));
            TOO_TALL:    h = $urandom_range(0, 1) ? 16'hFFFF :
                             16'(m_cfg.max_height) + 16'($urandom_range(1, 3));
            default: ;
        endcase
        // The length matches the size unless the length itself is the flaw,
        // so each rejection has a single cause.
        len = 32'(w) * 32'(h) * 32'd2;
        if (flaw == BAD_LENGTH) len = len ^ (32'd1 << $urandom_range(0, 31));

        hdr_bits = {ftype, fid, w, h, len};
        sum = '0;
        for (int i = 0; i < sfd_pkg::HEADER_BYTES; i++) begin
            x = hdr_bits[87 - 8*i -: 8];
            sum = sum + 16'(x);
            push_byte(x, 1'b0, '0);
        end
        if (flaw != NO_FLAW) return;

        for (int i = 0; i < int'(len); i++) begin
            x = 8'($urandom_range(0, 255));
            sum = sum + 16'(x);
            push_byte(x, 1'b0, '0);
        end
        csum = $urandom_range(0, 1) ? sum : sum + 16'(sf) + 16'(ss);
        if ($urandom_range(0, 5) == 0) csum = csum ^ 16'(1 << $urandom_range(0, 15));
        if ($urandom_range(0, 1)) begin
            push_byte(csum[15:8], 1'b0, '0);
            push_byte(csum[7:0], 1'b0, '0);
        end else begin
            push_byte(csum[7:0], 1'b0, '0);
            push_byte(csum[15:8], 1'b0, '0);
        end
    endtask

    // The receiver changes its stall behavior whenever the low byte of ready_cycle
    // wraps to zero: always ready, randomly ready, a fixed rotating pattern, or
    // mostly stalled. Long stretches of full throughput come from the first.
    always @(posedge i_clk) begin
        ready_cycle <= ready_cycle + 1'b1;
        if (ready_cycle[7:0] == 8'h00) ready_mode <= t_recv_mode'($urandom_range(0, 3));
        case (ready_mode)
            ALWAYS_READY:  sink_ready <= 1'b1;
            RANDOM_READY:  sink_ready <= ($urandom_range(0, 3) != 0);
            PATTERN_READY: sink_ready <= STALL_PATTERN[ready_cycle[2:0]];
            default:       sink_ready <= (ready_cycle % 7 == 0);
        endcase
    end

    // Every event transaction is checked against the oldest expectation.
    // Values are read just after the edge, so they are the ones that the
    // handshake at this edge carried.
    always @(posedge i_clk) begin : event_check
        t_deframe_evt want;
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected event", 32'(evt_if.event_kind), 32'd0);
            end else begin
                want = pending_events.pop_front();
                if (evt_if.event_kind !== want.kind)
                    report_mismatch("event_kind", 32'(evt_if.event_kind), 32'(want.kind));
                if (evt_if.payload_byte !== want.payload)
                    report_mismatch("payload_byte", 32'(evt_if.payload_byte),
                                    32'(want.payload));
                if (evt_if.frame_id !== want.frame_id)
                    report_mismatch("frame_id", 32'(evt_if.frame_id), 32'(want.frame_id));
                if (evt_if.frame_width !== want.frame_width)
                    report_mismatch("frame_width", 32'(evt_if.frame_width),
                                    32'(want.frame_width));
                if (evt_if.frame_height !== want.frame_height)
                    report_mismatch("frame_height", 32'(evt_if.frame_height),
                                    32'(want.frame_height));
                if (evt_if.good_count !== want.good_count)
                    report_mismatch("good_count", evt_if.good_count, want.good_count);
                if (evt_if.bad_count !== want.bad_count)
                    report_mismatch("bad_count", evt_if.bad_count, want.bad_count);
            end
        end
    end

    initial begin : stimulus
        sfd_pkg::t_cfg c;
        int            phase_start;
        int            pick;

        reset_model();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= sfd_pkg::CFG_SYNC_FIRST;
        i_cfg_data    <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run with the reset register values: both sync
        // bytes are zero, the type is one and the limits are 640 by 480.
        // A stray byte while hunting, then a header rejected for its type.
        add_row(8'h55);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h02);
        add_row(8'h12);
        add_row(8'h34);
        add_row(8'h00);
        add_row(8'h02);
        add_row(8'h00);
        add_row(8'h03);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h0C, 1'b1, t_deframe_evt'{sfd_pkg::EVT_BAD_HDR, 8'h00, 16'h1234,
                                            16'd2, 16'd3, 32'd0, 32'd1});
        // The smallest frame, one by one pixel, with the largest frame id.
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h01);
        add_row(8'hFF);
        add_row(8'hFF);
        add_row(8'h00);
        add_row(8'h01);
        add_row(8'h00);
        add_row(8'h01);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h02, 1'b1, t_deframe_evt'{sfd_pkg::EVT_HDR_OK, 8'h00, 16'hFFFF,
                                            16'd1, 16'd1, 32'd0, 32'd1});
        add_row(8'hFF);
        add_row(8'h00);
        // Header and payload sum to 0x0302, sent most significant byte first.
        add_row(8'h03);
        add_row(8'h02, 1'b1, t_deframe_evt'{sfd_pkg::EVT_FRAME_OK, 8'h00, 16'hFFFF,
                                            16'd1, 16'd1, 32'd1, 32'd1});
        foreach (dir_rows[i]) push_byte(dir_rows[i].rx, dir_rows[i].fixed, dir_rows[i].want);
        wait_drained();

        // Random part in phases, each with its own register setting.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: c = sfd_pkg::t_cfg'{8'hA5, 8'h5A, 8'h01, 10'd640, 9'd480};
                1: c = sfd_pkg::t_cfg'{8'hFF, 8'hFF, 8'hFF, 10'd1, 9'd1};
                2: c = sfd_pkg::t_cfg'{8'h00, 8'hFF, 8'h00, 10'd7, 9'd5};
                3: begin
                    c.sync_first  = 8'($urandom_range(0, 255));
                    c.sync_second = c.sync_first;
                    c.frame_type  = 8'($urandom_range(0, 255));
                    c.max_width   = 10'($urandom_range(1, 24));
                    c.max_height  = 9'($urandom_range(1, 24));
                end
                4: begin
                    c.sync_first  = 8'($urandom_range(0, 255));
                    c.sync_second = 8'($urandom_range(0, 255));
                    c.frame_type  = 8'($urandom_range(0, 255));
                    c.max_width   = 10'($urandom_range(1, 640));
                    c.max_height  = 9'($urandom_range(1, 480));
                end
                default: c = sfd_pkg::t_cfg'{8'hC3, 8'h3C, 8'h80, 10'd640, 9'd480};
            endcase
            set_config(c);
            steady_source = (ph % 3 == 1);
            phase_start = bytes_accepted;
            while (bytes_accepted - phase_start < 290) begin
                pick = $urandom_range(0, 39);
                if (pick == 0) wait_drained();
                else if (pick < 7) send_noise();
                else send_frame();
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard limit on the run, far beyond the slowest legal schedule.
    initial begin : watchdog
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
